@@ hdl/ship_pkg.sv @@
// Shared types, widths and state codes for the signature-trained replacement block.
package ship_pkg;

   localparam int SET_IDX_W = 10;
   localparam int WAY_IDX_W = 4;
   localparam int SIG_IN_W  = 14;

   typedef struct packed {
      logic [SET_IDX_W-1:0] set_rem;
      logic                 hit;
      logic [WAY_IDX_W-1:0] hit_way;
      logic [SIG_IN_W-1:0]  signature;
   } req_type;

   typedef struct packed {
      logic [WAY_IDX_W-1:0] victim_way;
      logic                 was_miss;
      logic                 inserted_distant;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROW,
      ST_SCAN,
      ST_AGE,
      ST_HIT_CNT,
      ST_MISS_DEC,
      ST_MISS_INS
   } back_state_type;

endpackage

@@ hdl/ship_rrip_replacement.sv @@
// Top level: signature-trained RRIP victim selection with decoupled front and back.
//
//   channel    direction  handshake         payload
//   request    in         push / full       req_set_index, req_hit, req_hit_way, req_signature
//   response   out        pop / empty       rsp_victim_way, rsp_was_miss, rsp_inserted_distant
//
// Front: accept with reciprocal quotient, then hand-off; no new transaction until the hand-off.
// Back: hit ST_ROW then ST_HIT_CNT, hit on a way out of range ST_ROW only, miss ST_ROW, ST_SCAN
// (one way per cycle in the max scan), ST_AGE, ST_MISS_DEC, ST_MISS_INS; the back sets the sustained rate.
// After reset a clearing pass over max(SETS, 2**SIG_BITS) addresses zeroes both RAMs;
// no transaction starts in the back until it ends.
// A two-entry queue parts front and back; a two-entry queue holds results.
module ship_rrip_replacement import ship_pkg::*; #(
   parameter int SETS        = 1024,
   parameter int WAYS        = 16,
   parameter int SIG_BITS    = 14,
   parameter int COUNTER_MAX = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [SET_IDX_W-1:0] req_set_index,
   input  logic                 req_hit,
   input  logic [WAY_IDX_W-1:0] req_hit_way,
   input  logic [SIG_IN_W-1:0]  req_signature,
   output logic                 empty,
   input  logic                 pop,
   output logic [WAY_IDX_W-1:0] rsp_victim_way,
   output logic                 rsp_was_miss,
   output logic                 rsp_inserted_distant
);

   logic    fq_push, fq_full, fq_empty, fq_pop;
   req_type fq_in, fq_out;
   logic    rq_push, rq_full;
   rsp_type rq_in, rq_out;

   ship_front #(.SETS(SETS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .set_index (req_set_index),
      .hit       (req_hit),
      .hit_way   (req_hit_way),
      .signature (req_signature),
      .q_push    (fq_push),
      .q_item    (fq_in),
      .q_full    (fq_full)
   );

   ship_fifo #(.WIDTH($bits(req_type)), .DEPTH(2)) u_req_q (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data (fq_in),
      .full      (fq_full),
      .pop       (fq_pop),
      .pop_data  (fq_out),
      .empty     (fq_empty)
   );

   ship_back #(
      .SETS        (SETS),
      .WAYS        (WAYS),
      .SIG_BITS    (SIG_BITS),
      .COUNTER_MAX (COUNTER_MAX)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (fq_empty),
      .q_item   (fq_out),
      .q_pop    (fq_pop),
      .rsp_full (rq_full),
      .rsp_push (rq_push),
      .rsp_item (rq_in)
   );

   ship_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(2)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rq_push),
      .push_data (rq_in),
      .full      (rq_full),
      .pop       (pop),
      .pop_data  (rq_out),
      .empty     (empty)
   );

   assign rsp_victim_way       = rq_out.victim_way;
   assign rsp_was_miss         = rq_out.was_miss;
   assign rsp_inserted_distant = rq_out.inserted_distant;

endmodule

@@ hdl/ship_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ship_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/ship_fifo.sv @@
// Small register FIFO used between the front, the back and the result port.
module ship_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hdl/ship_front.sv @@
// Front stage: accept a transaction and reduce its set index modulo SETS.
module ship_front import ship_pkg::*; #(
   parameter int SETS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [SET_IDX_W-1:0] set_index,
   input  logic                 hit,
   input  logic [WAY_IDX_W-1:0] hit_way,
   input  logic [SIG_IN_W-1:0]  signature,
   output logic                 q_push,
   output req_type              q_item,
   input  logic                 q_full
);

   localparam int RECIP_SH = 24;
   localparam int PW       = SET_IDX_W + RECIP_SH + 1;
   localparam int QW       = SET_IDX_W + 13;
   localparam logic [RECIP_SH:0] RECIP = (RECIP_SH + 1)'((1 << RECIP_SH) / SETS + 1);

   logic                 busy_ff, busy_in;
   req_type              item_ff, item_in;
   logic [SET_IDX_W-1:0] quot_ff, quot_in;
   logic [PW-1:0]        prod;
   logic [QW-1:0]        qmul;

   assign full = busy_ff;
   assign prod = PW'(set_index) * PW'(RECIP);
   assign qmul = QW'(quot_ff) * QW'(SETS);

   always_comb begin
      q_item         = item_ff;
      q_item.set_rem = SET_IDX_W'(QW'(item_ff.set_rem) - qmul);
   end

   always_comb begin
      busy_in = busy_ff;
      item_in = item_ff;
      quot_in = quot_ff;
      q_push  = 1'b0;
      if (!busy_ff) begin
         if (push) begin
            busy_in           = 1'b1;
            item_in.set_rem   = set_index;
            item_in.hit       = hit;
            item_in.hit_way   = hit_way;
            item_in.signature = signature;
            quot_in           = prod[RECIP_SH +: SET_IDX_W];
         end
      end else if (!q_full) begin
         q_push  = 1'b1;
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      quot_ff <= quot_in;
   end

endmodule

@@ hdl/ship_back.sv @@
// Back stage: set row and counter table read-modify-write sequencer.
module ship_back import ship_pkg::*; #(
   parameter int SETS        = 1024,
   parameter int WAYS        = 16,
   parameter int SIG_BITS    = 14,
   parameter int COUNTER_MAX = 3
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  req_type q_item,
   output logic    q_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp_item
);

   localparam int W_W       = $clog2(WAYS);
   localparam int LINE_W    = W_W + 1 + SIG_BITS;
   localparam int ROW_W     = WAYS * LINE_W;
   localparam int CNT_W     = $clog2(COUNTER_MAX + 1);
   localparam int SIG_COUNT = 1 << SIG_BITS;
   localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int CLR_N     = (SETS > SIG_COUNT) ? SETS : SIG_COUNT;
   localparam int CLR_W     = $clog2(CLR_N);
   localparam logic [W_W-1:0]   FAR  = W_W'(WAYS - 1);
   localparam logic [W_W-1:0]   NEAR = W_W'(WAYS - 2);
   localparam logic [CNT_W-1:0] CMAX = CNT_W'(COUNTER_MAX);

   back_state_type      state_ff, state_in;
   req_type             item_ff, item_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [W_W-1:0]      scan_ff, scan_in;
   logic [W_W-1:0]      top_ff, top_in;
   logic [W_W-1:0]      victim_ff, victim_in;
   logic [SIG_BITS-1:0] old_ff, old_in;
   logic                vreused_ff, vreused_in;
   logic [CNT_W-1:0]    dec_ff, dec_in;
   logic [CLR_W-1:0]    clr_ff, clr_in;

   logic                row_wr_en, row_rd_en;
   logic [SET_W-1:0]    row_wr_addr, row_rd_addr;
   logic [ROW_W-1:0]    row_wr_data, row_rd_data;
   logic                cnt_wr_en, cnt_rd_en;
   logic [SIG_BITS-1:0] cnt_wr_addr, cnt_rd_addr;
   logic [CNT_W-1:0]    cnt_wr_data, cnt_rd_data;

   logic [W_W-1:0]      hw;
   logic [LINE_W-1:0]   line;
   logic [W_W-1:0]      cur;
   logic [W_W-1:0]      lift;
   logic [CNT_W-1:0]    cval;
   logic                distant;
   logic [SIG_BITS-1:0] nsig;
   logic [SET_W-1:0]    set_addr;

   assign nsig     = SIG_BITS'(item_ff.signature);
   assign set_addr = SET_W'(item_ff.set_rem);
   assign hw       = W_W'(item_ff.hit_way);

   ship_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (row_wr_addr),
      .wr_data (row_wr_data),
      .rd_en   (row_rd_en),
      .rd_addr (row_rd_addr),
      .rd_data (row_rd_data)
   );

   ship_ram #(.WIDTH(CNT_W), .DEPTH(SIG_COUNT)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      row_in      = row_ff;
      scan_in     = scan_ff;
      top_in      = top_ff;
      victim_in   = victim_ff;
      old_in      = old_ff;
      vreused_in  = vreused_ff;
      dec_in      = dec_ff;
      clr_in      = clr_ff;
      row_wr_en   = 1'b0;
      row_wr_addr = set_addr;
      row_wr_data = row_ff;
      row_rd_en   = 1'b0;
      row_rd_addr = SET_W'(q_item.set_rem);
      cnt_wr_en   = 1'b0;
      cnt_wr_addr = old_ff;
      cnt_wr_data = '0;
      cnt_rd_en   = 1'b0;
      cnt_rd_addr = nsig;
      q_pop       = 1'b0;
      rsp_push    = 1'b0;
      rsp_item    = '0;
      line        = '0;
      cur         = '0;
      lift        = '0;
      cval        = '0;
      distant     = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            row_wr_en   = 1'b1;
            row_wr_addr = SET_W'(clr_ff);
            row_wr_data = '0;
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = SIG_BITS'(clr_ff);
            cnt_wr_data = '0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == CLR_W'(CLR_N - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty && !rsp_full) begin
               q_pop     = 1'b1;
               item_in   = q_item;
               row_rd_en = 1'b1;
               state_in  = ST_ROW;
            end
         end
         ST_ROW: begin
            row_in = row_rd_data;
            if (item_ff.hit) begin
               if (6'(item_ff.hit_way) >= 6'(WAYS)) begin
                  rsp_push = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  line        = row_rd_data[hw*LINE_W +: LINE_W];
                  old_in      = line[LINE_W-1:W_W+1];
                  cnt_rd_en   = 1'b1;
                  cnt_rd_addr = line[LINE_W-1:W_W+1];
                  row_in[hw*LINE_W +: LINE_W] = {line[LINE_W-1:W_W+1], 1'b1, {W_W{1'b0}}};
                  state_in    = ST_HIT_CNT;
               end
            end else begin
               scan_in   = '0;
               top_in    = '0;
               victim_in = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cur = row_ff[scan_ff*LINE_W +: W_W];
            if (cur > top_ff) begin
               top_in    = cur;
               victim_in = scan_ff;
            end
            if (scan_ff == W_W'(WAYS - 1)) begin
               state_in = ST_AGE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_AGE: begin
            lift = FAR - top_ff;
            for (int w = 0; w < WAYS; w++) begin
               row_in[w*LINE_W +: W_W] = row_ff[w*LINE_W +: W_W] + lift;
            end
            line        = row_ff[victim_ff*LINE_W +: LINE_W];
            old_in      = line[LINE_W-1:W_W+1];
            vreused_in  = line[W_W];
            cnt_rd_en   = 1'b1;
            cnt_rd_addr = line[LINE_W-1:W_W+1];
            state_in    = ST_MISS_DEC;
         end
         ST_MISS_DEC: begin
            cval = cnt_rd_data;
            if (!vreused_ff && cval != '0) begin
               cval = cval - 1'b1;
            end
            dec_in      = cval;
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = old_ff;
            cnt_wr_data = cval;
            cnt_rd_en   = 1'b1;
            cnt_rd_addr = nsig;
            state_in    = ST_MISS_INS;
         end
         ST_MISS_INS: begin
            cval    = (nsig == old_ff) ? dec_ff : cnt_rd_data;
            distant = (cval == '0);
            row_in[victim_ff*LINE_W +: LINE_W] = {nsig, 1'b0, distant ? FAR : NEAR};
            row_wr_en   = 1'b1;
            row_wr_data = row_in;
            rsp_push    = 1'b1;
            rsp_item.victim_way       = WAY_IDX_W'(victim_ff);
            rsp_item.was_miss         = 1'b1;
            rsp_item.inserted_distant = distant;
            state_in    = ST_IDLE;
         end
         ST_HIT_CNT: begin
            cval        = cnt_rd_data;
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = old_ff;
            cnt_wr_data = (cval < CMAX) ? cval + 1'b1 : cval;
            row_wr_en   = 1'b1;
            row_wr_data = row_ff;
            rsp_push    = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      row_ff     <= row_in;
      scan_ff    <= scan_in;
      top_ff     <= top_in;
      victim_ff  <= victim_in;
      old_ff     <= old_in;
      vreused_ff <= vreused_in;
      dec_ff     <= dec_in;
   end

endmodule

@@ dv/ship_rrip_replacement_tb.sv @@
// Self-checking testbench for the signature-trained RRIP replacement block.
module tb_top;
   import ship_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETS        = 1024;
   localparam int WAYS        = 16;
   localparam int SIG_BITS    = 14;
   localparam int COUNTER_MAX = 3;
   localparam int WATCHDOG    = 100000;

   class ship_scoreboard;
      logic [3:0]          rrpv [SETS*WAYS];
      bit                  reused [SETS*WAYS];
      logic [SIG_BITS-1:0] line_sig [SETS*WAYS];
      logic [1:0]          sig_count [2**SIG_BITS];
      rsp_type             pending [$];
      int                  mismatches;

      function new();
         foreach (rrpv[i]) begin
            rrpv[i] = 0;
            reused[i] = 0;
            line_sig[i] = 0;
         end
         foreach (sig_count[i]) sig_count[i] = 0;
         mismatches = 0;
      endfunction

      function void note_access(req_type acc);
         int      base;
         int      idx;
         int      victim;
         int      top;
         int      lift;
         rsp_type r;
         logic [SIG_BITS-1:0] old_sig;
         r = '0;
         base = (acc.set_rem % SETS) * WAYS;
         if (acc.hit) begin
            if (acc.hit_way < WAYS) begin
               idx = base + acc.hit_way;
               old_sig = line_sig[idx];
               rrpv[idx] = 0;
               reused[idx] = 1;
               if (sig_count[old_sig] < COUNTER_MAX) sig_count[old_sig]++;
            end
         end else begin
            top = 0;
            victim = 0;
            for (int w = 0; w < WAYS; w++) begin
               if (rrpv[base+w] > top) begin
                  top = rrpv[base+w];
                  victim = w;
               end
            end
            if (top > WAYS-1) top = WAYS-1;
            lift = WAYS-1-top;
            for (int w = 0; w < WAYS; w++) rrpv[base+w] = rrpv[base+w] + lift;
            idx = base + victim;
            old_sig = line_sig[idx];
            if (!reused[idx] && sig_count[old_sig] > 0) sig_count[old_sig]--;
            r.inserted_distant = (sig_count[acc.signature[SIG_BITS-1:0]] == 0);
            rrpv[idx] = r.inserted_distant ? WAYS-1 : WAYS-2;
            reused[idx] = 0;
            line_sig[idx] = acc.signature[SIG_BITS-1:0];
            r.victim_way = victim[3:0];
            r.was_miss = 1;
         end
         pending.push_back(r);
      endfunction

      function bit check_result(rsp_type got);
         rsp_type exp;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return 0;
         end
         exp = pending.pop_front();
         if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp, got);
            return 0;
         end
         return 1;
      endfunction
   endclass

   logic clock, reset, push, pop;
   logic full, empty;
   logic [SET_IDX_W-1:0] req_set_index;
   logic                 req_hit;
   logic [WAY_IDX_W-1:0] req_hit_way;
   logic [SIG_IN_W-1:0]  req_signature;
   logic [WAY_IDX_W-1:0] rsp_victim_way;
   logic                 rsp_was_miss, rsp_inserted_distant;

   ship_scoreboard sb;
   int  send_idle_pct, recv_stall_pct;
   bit  hold_recv;
   int  quiet_cycles;
   bit  timed_out;

   ship_rrip_replacement #(
      .SETS(SETS), .WAYS(WAYS), .SIG_BITS(SIG_BITS), .COUNTER_MAX(COUNTER_MAX)
   ) i_dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   task automatic send_access(logic [9:0] set_idx, logic is_hit, logic [3:0] way,
                              logic [13:0] sig);
      req_type acc;
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 0;
         @(posedge clock);
      end
      push <= 1;
      req_set_index <= set_idx;
      req_hit <= is_hit;
      req_hit_way <= way;
      req_signature <= sig;
      acc.set_rem = set_idx;
      acc.hit = is_hit;
      acc.hit_way = way;
      acc.signature = sig;
      do @(posedge clock); while (full);
      sb.note_access(acc);
   endtask

   task automatic send_random(int count);
      logic [9:0] s;
      for (int i = 0; i < count; i++) begin
         s = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(7));
         if ($urandom_range(9) == 0)
            send_access(s, 1'($urandom), 4'($urandom), 14'($urandom));
         else
            send_access(s, $urandom_range(99) < 45, 4'($urandom),
                        14'($urandom_range(15) | ($urandom_range(3) == 0 ? $urandom : 0)));
      end
   endtask

   task automatic drain();
      push <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 0;
      end else begin
         if (pop && !empty)
            void'(sb.check_result('{rsp_victim_way, rsp_was_miss, rsp_inserted_distant}));
         pop <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG && !timed_out) begin
            timed_out <= 1;
            $display("ship_rrip_replacement verification failed");
            $finish;
         end
      end
   end

   initial begin
      sb = new();
      push = 0; reset = 1; hold_recv = 0;
      req_set_index = 0; req_hit = 0; req_hit_way = 0; req_signature = 0;
      send_idle_pct = 0; recv_stall_pct = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_access(10'd0, 0, 4'd0, 14'd0);
      send_access(10'd0, 1, 4'd0, 14'd0);
      send_access(10'd0, 0, 4'd15, 14'h3fff);
      send_access(10'd1023, 0, 4'd0, 14'h3fff);
      send_access(10'd1023, 1, 4'd15, 14'h2aaa);
      send_access(10'd1023, 1, 4'd15, 14'h1555);
      send_access(10'd1023, 1, 4'd15, 14'h1555);
      send_access(10'd1023, 1, 4'd15, 14'h1555);
      for (int i = 0; i < 17; i++) send_access(10'd5, 0, 4'd0, 14'd7);
      drain();
      hold_recv = 1;
      fork
         send_random(12);
         begin
            repeat (300) @(posedge clock);
            hold_recv = 0;
         end
      join
      drain();
      send_random(330);
      send_idle_pct = 46;
      send_random(330);
      send_idle_pct = 0; recv_stall_pct = 46;
      send_random(330);
      send_idle_pct = 22; recv_stall_pct = 22;
      send_random(330);
      drain();
      repeat (100) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("ship_rrip_replacement verification clean");
      else
         $display("ship_rrip_replacement verification failed");
      $finish;
   end
endmodule

@@ filelist.f @@
hdl/ship_pkg.sv
hdl/ship_ram.sv
hdl/ship_fifo.sv
hdl/ship_front.sv
hdl/ship_back.sv
hdl/ship_rrip_replacement.sv
dv/ship_rrip_replacement_tb.sv
